// ===== src/lsw_pkg.sv =====
package lsw_pkg;

	// Pixel word and the two reserved pixel values.
	typedef logic [7:0] pix_t;

	localparam pix_t PIX_WALL = 8'd0;
	localparam pix_t PIX_FREE = 8'd255;

	// Input word kinds.
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_PAD   = 1'b1;

	// Configuration port layout and register indexes.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	// 3x3 window, indexed [row][column], row 0 on top, column 0 on the left.
	typedef logic [2:0][2:0][7:0] win_t;

	// Which window borders lie inside the image.
	typedef struct packed {
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
	} edge_t;

	// A free centre takes the last labelled neighbour in raster order.
	// Neighbours outside the image read as wall.
	function automatic pix_t spread(win_t win, edge_t ok);
		pix_t res;
		pix_t v;
		logic rok;
		logic cok;
		res = win[1][1];
		if (win[1][1] == PIX_FREE) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					rok = (i == 0) ? ok.top_ok : ((i == 2) ? ok.bot_ok : 1'b1);
					cok = (j == 0) ? ok.left_ok : ((j == 2) ? ok.right_ok : 1'b1);
					v = (rok && cok) ? win[i][j] : PIX_WALL;
					if (v != PIX_WALL && v != PIX_FREE) begin
						res = v;
					end
				end
			end
		end
		return res;
	endfunction

endpackage

// ===== src/lsw_ifs.sv =====
// Pixel input channel.
interface lsw_pix_in_if;
	import lsw_pkg::*;
	logic valid;
	logic ready;
	logic command;
	pix_t pixel_in;
	logic first_of_frame;
	modport source(output valid, command, pixel_in, first_of_frame, input ready);
	modport sink(input valid, command, pixel_in, first_of_frame, output ready);
endinterface

// Pixel result channel.
interface lsw_pix_out_if;
	import lsw_pkg::*;
	logic valid;
	logic ready;
	pix_t pixel_out;
	logic last_out;
	modport source(output valid, pixel_out, last_out, input ready);
	modport sink(input valid, pixel_out, last_out, output ready);
endinterface

// Configuration write channel.
interface lsw_cfg_if;
	import lsw_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== src/lsw_line_mem.sv =====
module lsw_line_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_data
);
	import lsw_pkg::*;

	// Two line buffers side by side: upper byte is the line above, lower the middle line.
	logic [15:0] mem_q [DEPTH];
	logic [15:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/label_spread_window_3x3_unit.sv =====
// The result for a pixel passes through stage 1 and the output register once the word
// carrying the pixel width+1 positions later is accepted; pad words flush the frame end.
// Throughput: one word per cycle unless the output stalls, set by the single read and write
// port of the line memory; a same-column read in the cycle of the write-back is forwarded.
// Reset: asynchronous, active low; clears counters, window, pipeline valids and
// sets the image size to 640 x 480. The line memory is not cleared.
module label_spread_window_3x3_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	lsw_pix_in_if.sink        pix_in,
	lsw_pix_out_if.source     pix_out,
	lsw_cfg_if.sink           cfg
);
	import lsw_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 3);
	localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
	localparam int H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

	// Configuration and frame size.
	logic [CW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [PW-1:0] wh_q;

	// Input position.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [PW-1:0] opos_q;

	// Stage 1: waits for the line memory read.
	logic          valid_s1;
	logic [AW-1:0] addr_s1;
	pix_t          px_s1;
	logic          emit_s1;
	logic          last_s1;
	edge_t         edge_s1;
	logic          fwd_s1;
	pix_t          fwd_top_s1;
	pix_t          fwd_mid_s1;

	// Window and output register.
	win_t win_q;
	logic out_valid_q;
	pix_t pixel_out_q;
	logic last_out_q;

	// Stage 0 combinational signals.
	logic          accept;
	logic          s1_fire;
	logic          fof;
	pix_t          px0;
	logic [CW-1:0] col0;
	logic [RW-1:0] row0;
	logic [PW-1:0] opos0;
	logic [CW-1:0] c;
	logic [RW-1:0] r;
	logic [RW-1:0] cr;
	logic          n;
	logic          emit;
	logic [PW-1:0] opos_nx;
	logic [CW-1:0] c_nx;
	edge_t         edge0;
	logic [CW-1:0] w_cfg;
	logic [HW-1:0] h_cfg;

	// Stage 1 combinational signals.
	logic [15:0] rd_data;
	pix_t        top_eff;
	pix_t        mid_eff;
	win_t        win_nx;

	// Configuration writes, with out-of-range sizes clamped on the way in.
	assign cfg.ready = 1'b1;

	always_comb begin
		if (cfg.data == '0) begin
			w_cfg = CW'(1);
			h_cfg = HW'(1);
		end else begin
			w_cfg = (32'(cfg.data) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(cfg.data);
			h_cfg = (32'(cfg.data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg.data);
		end
	end

	// The frame area follows a size write in the same cycle as the size itself.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q  <= CW'(W_RST);
			h_q  <= HW'(H_RST);
			wh_q <= PW'(W_RST * H_RST);
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_IMAGE_WIDTH: begin
						w_q  <= w_cfg;
						wh_q <= PW'(w_cfg) * PW'(h_q);
					end
					REG_IMAGE_HEIGHT: begin
						h_q  <= h_cfg;
						wh_q <= PW'(w_q) * PW'(h_cfg);
					end
					default: ;
				endcase
			end
		end
	end

	// Handshake: stage 1 moves on whenever the output register is free or being emptied.
	assign s1_fire      = valid_s1 && (!out_valid_q || pix_out.ready);
	assign pix_in.ready = !valid_s1 || s1_fire;
	assign accept       = pix_in.valid && pix_in.ready;

	// Stage 0: position bookkeeping and the choice of whether this word yields a result.
	always_comb begin
		fof   = (pix_in.command == CMD_PIXEL) && pix_in.first_of_frame;
		px0   = (pix_in.command == CMD_PAD) ? PIX_WALL : pix_in.pixel_in;
		col0  = fof ? '0 : col_q;
		row0  = fof ? '0 : row_q;
		opos0 = fof ? '0 : opos_q;
		if (col0 >= w_q) begin
			c = '0;
			r = (row0 < RW'(MAX_HEIGHT + 2)) ? row0 + RW'(1) : row0;
		end else begin
			c = col0;
			r = row0;
		end
		// The window centre trails the input by one row and one column.
		if (c != '0) begin
			n  = (r >= RW'(1));
			cr = r - RW'(1);
			edge0.left_ok  = (c >= CW'(2));
			edge0.right_ok = 1'b1;
		end else begin
			n  = (r >= RW'(2));
			cr = r - RW'(2);
			edge0.left_ok  = (w_q > CW'(1));
			edge0.right_ok = 1'b0;
		end
		edge0.top_ok = (cr != '0);
		edge0.bot_ok = ((cr + RW'(1)) < RW'(h_q));
		emit    = n && (cr < RW'(h_q)) && (opos0 < wh_q);
		opos_nx = opos0 + PW'(emit);
		c_nx    = c + CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			opos_q <= '0;
		end else if (accept) begin
			opos_q <= opos_nx;
			if (c_nx >= w_q) begin
				col_q <= '0;
				row_q <= (r < RW'(MAX_HEIGHT + 2)) ? r + RW'(1) : r;
			end else begin
				col_q <= c_nx;
				row_q <= r;
			end
		end
	end

	// Line memory: read at accept, written back as the word leaves stage 1.
	lsw_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (c[AW-1:0]),
		.rd_data (rd_data),
		.wr_en   (s1_fire),
		.wr_addr (addr_s1),
		.wr_data ({mid_eff, px_s1})
	);

	// Stage 1 register; a read that meets the write-back of the same column is forwarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1    <= c[AW-1:0];
			px_s1      <= px0;
			emit_s1    <= emit;
			last_s1    <= emit && (opos_nx == wh_q);
			edge_s1    <= edge0;
			fwd_s1     <= s1_fire && (addr_s1 == c[AW-1:0]);
			fwd_top_s1 <= mid_eff;
			fwd_mid_s1 <= px_s1;
		end
	end

	assign top_eff = fwd_s1 ? fwd_top_s1 : rd_data[15:8];
	assign mid_eff = fwd_s1 ? fwd_mid_s1 : rd_data[7:0];

	// Window shift: the new column enters on the right.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_nx[i][0] = win_q[i][1];
			win_nx[i][1] = win_q[i][2];
		end
		win_nx[0][2] = top_eff;
		win_nx[1][2] = mid_eff;
		win_nx[2][2] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_fire) begin
			win_q <= win_nx;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit_s1) begin
			pixel_out_q <= spread(win_nx, edge_s1);
			last_out_q  <= last_s1;
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.pixel_out = pixel_out_q;
	assign pix_out.last_out  = last_out_q;

	// An accepted word always lands in stage 1.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted word did not reach stage 1");

	// A stalled stage 1 word keeps its column, so the write-back goes to the right entry.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_fire) |=> (valid_s1 && $stable(addr_s1)))
		else $error("stage 1 lost its word while stalled");

	// The input stalls only when both stage 1 and the output register are full.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> (valid_s1 && out_valid_q))
		else $error("input stalled with room in the pipeline");

endmodule
